/* hw/rtl/iq_upconvert_mixer_core_assert.svh */
// ----------------------------------------------------------------------------
// iq upconvert mixer assertion macros
// shared concurrent assertion forms, sampled on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef IQ_UPCONVERT_MIXER_CORE_ASSERT_SVH
`define IQ_UPCONVERT_MIXER_CORE_ASSERT_SVH

// condition that holds at every edge
`define IQUM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define IQUM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IQUM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/iqum_pkg.sv */
// ----------------------------------------------------------------------------
// iqum_pkg
// shared constants, types and helpers of the iq upconvert mixer
// ----------------------------------------------------------------------------
package iqum_pkg;

    localparam int MAX_UPSAMPLE = 64;
    localparam int SAMPLE_BITS  = 8;
    localparam int TABLE_DEPTH  = 64;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int COEF_W       = 16;
    localparam int PROD_W       = SAMPLE_BITS + COEF_W;
    localparam int FRAC_W       = COEF_W - 1;
    // truncated product spans [-(2^(SAMPLE_BITS-1)-1), 2^(SAMPLE_BITS-1)]
    localparam int TERM_W       = SAMPLE_BITS + 1;
    localparam int SUM_W        = TERM_W + 1;
    localparam int COUNT_W      = 7;
    localparam int RUN_MAX      = (MAX_UPSAMPLE < TABLE_DEPTH) ? MAX_UPSAMPLE : TABLE_DEPTH;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_IDX_W    = 1;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MIX  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UPSAMPLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC       = 1'b1;

    // tag that travels alongside the coefficient read
    typedef struct packed {
        logic                          valid;
        logic                          last;
        logic signed [SAMPLE_BITS-1:0] i_val;
        logic signed [SAMPLE_BITS-1:0] q_val;
    } iqum_tag_t;

    // product scaled by 2^-15, rounded toward zero
    function automatic logic signed [TERM_W-1:0] trunc_q15(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] bias;
        logic signed [PROD_W-1:0] r;
        bias = p[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : '0;
        r    = (p + bias) >>> FRAC_W;
        return r[TERM_W-1:0];
    endfunction

endpackage

/* hw/rtl/iqum_if.sv */
// ----------------------------------------------------------------------------
// iqum channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface iqum_in_if
    import iqum_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [ADDR_W-1:0]             phase_index;
    logic signed [COEF_W-1:0]      cos_coef;
    logic signed [COEF_W-1:0]      sin_coef;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic signed [SAMPLE_BITS-1:0] q_sample;

    modport source (
        output valid, command, phase_index, cos_coef, sin_coef, i_sample, q_sample,
        input  ready
    );
    modport sink (
        input  valid, command, phase_index, cos_coef, sin_coef, i_sample, q_sample,
        output ready
    );
endinterface

interface iqum_out_if
    import iqum_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_byte;
    logic                   clipped;
    logic                   last;
    logic [COUNT_W-1:0]     clip_count;

    modport source (
        output valid, sample_byte, clipped, last, clip_count,
        input  ready
    );
    modport sink (
        input  valid, sample_byte, clipped, last, clip_count,
        output ready
    );
endinterface

/* hw/rtl/iq_upconvert_mixer_core.sv */
// ----------------------------------------------------------------------------
// iq_upconvert_mixer_core
// quadrature upconversion mixer with a 64-entry cos/sin carrier ram
// ----------------------------------------------------------------------------
//  channel   dir   handshake      carries
//  mix_in    in    valid/ready    load or mix item (command, phase, coefs, i/q)
//  mix_out   out   valid/ready    output byte, clip flag, last, clip count
//  cfg       in    cfg_we only    upsample_count (index 0), dc_offset (index 1)
//
//  a load transaction writes one ram entry; a mix transaction, once accepted,
//  sweeps upsample_count ram entries (clamped to 1..64), one entry a cycle
//  unless mix_out stalls; reads pass the ram read, product and result registers
//  the ram read port sets the output rate: one result per unstalled sweep cycle
//  reset clears control only; the ram is undefined until loaded
//  a stalled mix_out freezes the read sweep and the whole pipeline
// ----------------------------------------------------------------------------
`include "iq_upconvert_mixer_core_assert.svh"

module iq_upconvert_mixer_core
    import iqum_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    iqum_in_if.sink               mix_in,
    iqum_out_if.source            mix_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    logic [COUNT_W-1:0]            upsample_count_reg, upsample_count_next;
    logic [SAMPLE_BITS-1:0]        dc_offset_reg, dc_offset_next;

    // read sweep control
    logic                          busy_reg, busy_next;
    logic [ADDR_W-1:0]             idx_reg, idx_next;
    logic [ADDR_W-1:0]             last_idx_reg, last_idx_next;
    logic signed [SAMPLE_BITS-1:0] i_reg;
    logic signed [SAMPLE_BITS-1:0] q_reg;
    iqum_tag_t                     tag_reg, tag_next;

    logic                          in_fire;
    logic                          is_mix;
    logic                          adv;
    logic                          issue;
    logic [ADDR_W-1:0]             eff_last;
    logic [2*COEF_W-1:0]           ram_rdata;

    // pipeline moves whenever the result register is free or being drained
    assign adv     = !mix_out.valid || mix_out.ready;
    assign issue   = busy_reg && adv;

    // one item in flight at the front: no new transaction during a sweep
    assign mix_in.ready = !busy_reg;
    assign in_fire      = mix_in.valid && mix_in.ready;
    assign is_mix       = (mix_in.command == CMD_MIX);

    // clamp the run length to 1..RUN_MAX, kept as the last table index
    always_comb
    begin
        if (upsample_count_reg == '0)
        begin
            eff_last = '0;
        end
        else if (upsample_count_reg > COUNT_W'(RUN_MAX))
        begin
            eff_last = ADDR_W'(RUN_MAX - 1);
        end
        else
        begin
            eff_last = ADDR_W'(upsample_count_reg - COUNT_W'(1));
        end
    end

    // configuration decode
    always_comb
    begin
        upsample_count_next = upsample_count_reg;
        dc_offset_next      = dc_offset_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UPSAMPLE: upsample_count_next = cfg_wdata[COUNT_W-1:0];
                CFG_DC:       dc_offset_next      = cfg_wdata[SAMPLE_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // sweep sequencing and the tag that rides with the ram read
    always_comb
    begin
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        tag_next      = tag_reg;
        if (in_fire && is_mix)
        begin
            busy_next     = 1'b1;
            idx_next      = '0;
            last_idx_next = eff_last;
        end
        else if (issue)
        begin
            idx_next = idx_reg + ADDR_W'(1);
            if (idx_reg == last_idx_reg)
            begin
                busy_next = 1'b0;
            end
        end
        if (adv)
        begin
            tag_next.valid = busy_reg;
            tag_next.last  = (idx_reg == last_idx_reg);
            tag_next.i_val = i_reg;
            tag_next.q_val = q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upsample_count_reg <= COUNT_W'(1);
            dc_offset_reg      <= '0;
            busy_reg           <= 1'b0;
            idx_reg            <= '0;
            last_idx_reg       <= '0;
            tag_reg            <= '0;
        end
        else
        begin
            upsample_count_reg <= upsample_count_next;
            dc_offset_reg      <= dc_offset_next;
            busy_reg           <= busy_next;
            idx_reg            <= idx_next;
            last_idx_reg       <= last_idx_next;
            tag_reg            <= tag_next;
        end
    end

    // samples of the current mix transaction, payload only
    always_ff @(posedge clk)
    begin
        if (in_fire && is_mix)
        begin
            i_reg <= mix_in.i_sample;
            q_reg <= mix_in.q_sample;
        end
    end

    // carrier table: cosine in the upper half, sine in the lower half
    iqum_ram #(
        .WIDTH (2 * COEF_W),
        .DEPTH (TABLE_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (in_fire && !is_mix),
        .waddr (mix_in.phase_index),
        .wdata ({mix_in.cos_coef, mix_in.sin_coef}),
        .re    (issue),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    iqum_mix u_mix (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .tag            (tag_reg),
        .cos_rd         (ram_rdata[2*COEF_W-1:COEF_W]),
        .sin_rd         (ram_rdata[COEF_W-1:0]),
        .dc_offset      (dc_offset_reg),
        .res_valid      (mix_out.valid),
        .res_byte       (mix_out.sample_byte),
        .res_clipped    (mix_out.clipped),
        .res_last       (mix_out.last),
        .res_clip_count (mix_out.clip_count)
    );

    // sweep never runs past the clamped run length
    `IQUM_ASSERT_IMPLY(a_idx_in_run, busy_reg, idx_reg <= last_idx_reg, "sweep index past run end")
    // an accepted mix starts its sweep at entry zero
    `IQUM_ASSERT_NEXT(a_mix_starts, in_fire && is_mix, busy_reg && idx_reg == '0, "no sweep start")
    // clip count is only reported on the closing result
    `IQUM_ASSERT_IMPLY(a_cc_on_last, mix_out.valid && !mix_out.last, ~|mix_out.clip_count, "cc")

endmodule

/* hw/rtl/iqum_ram.sv */
// ----------------------------------------------------------------------------
// iqum_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module iqum_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/iqum_mix.sv */
// ----------------------------------------------------------------------------
// iqum_mix
// product register, then truncate/sum/saturate logic into the result register
// ----------------------------------------------------------------------------
module iqum_mix
    import iqum_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  iqum_tag_t                     tag,
    input  logic signed [COEF_W-1:0]      cos_rd,
    input  logic signed [COEF_W-1:0]      sin_rd,
    input  logic [SAMPLE_BITS-1:0]        dc_offset,
    output logic                          res_valid,
    output logic [SAMPLE_BITS-1:0]        res_byte,
    output logic                          res_clipped,
    output logic                          res_last,
    output logic [COUNT_W-1:0]            res_clip_count
);

    localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

    logic                      p_valid_reg, p_valid_next;
    logic                      p_last_reg, p_last_next;
    logic signed [PROD_W-1:0]  pi_reg;
    logic signed [PROD_W-1:0]  pq_reg;
    logic                      o_valid_reg, o_valid_next;
    logic                      o_last_reg, o_last_next;
    logic                      o_clip_reg, o_clip_next;
    logic [SAMPLE_BITS-1:0]    o_byte_reg, o_byte_next;
    logic [COUNT_W-1:0]        o_cc_reg, o_cc_next;
    logic [COUNT_W-1:0]        acc_reg, acc_next;

    logic signed [TERM_W-1:0]  ti, tq;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   sat;
    logic                      clip;
    logic [COUNT_W-1:0]        acc_inc;

    always_comb
    begin
        ti   = trunc_q15(pi_reg);
        tq   = trunc_q15(pq_reg);
        sum  = SUM_W'(ti) + SUM_W'(tq);
        clip = 1'b0;
        sat  = sum;
        if (sum > SMAX)
        begin
            sat  = SMAX;
            clip = 1'b1;
        end
        else if (sum < SMIN)
        begin
            sat  = SMIN;
            clip = 1'b1;
        end
        acc_inc = acc_reg + COUNT_W'(clip);
    end

    always_comb
    begin
        p_valid_next = p_valid_reg;
        p_last_next  = p_last_reg;
        o_valid_next = o_valid_reg;
        o_last_next  = o_last_reg;
        o_clip_next  = o_clip_reg;
        o_byte_next  = o_byte_reg;
        o_cc_next    = o_cc_reg;
        acc_next     = acc_reg;
        if (adv)
        begin
            p_valid_next = tag.valid;
            p_last_next  = tag.last;
            o_valid_next = p_valid_reg;
            if (p_valid_reg)
            begin
                o_last_next = p_last_reg;
                o_clip_next = clip;
                o_byte_next = sat[SAMPLE_BITS-1:0] + dc_offset;
                o_cc_next   = p_last_reg ? acc_inc : '0;
                acc_next    = p_last_reg ? '0 : acc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            o_valid_reg <= 1'b0;
            o_last_reg  <= 1'b0;
            o_clip_reg  <= 1'b0;
            o_cc_reg    <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            p_last_reg  <= p_last_next;
            o_valid_reg <= o_valid_next;
            o_last_reg  <= o_last_next;
            o_clip_reg  <= o_clip_next;
            o_cc_reg    <= o_cc_next;
            acc_reg     <= acc_next;
        end
    end

    // products are payload, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pi_reg <= PROD_W'(tag.i_val) * PROD_W'(cos_rd);
            pq_reg <= PROD_W'(tag.q_val) * PROD_W'(sin_rd);
        end
        o_byte_reg <= o_byte_next;
    end

    assign res_valid      = o_valid_reg;
    assign res_byte       = o_byte_reg;
    assign res_clipped    = o_clip_reg;
    assign res_last       = o_last_reg;
    assign res_clip_count = o_cc_reg;

endmodule

/* tb/iq_upconvert_mixer_core_tb.sv */
// ----------------------------------------------------------------------------
// iq_upconvert_mixer_core_tb
// self-checking bench for the quadrature upconversion mixer: a directed
// opening on the coefficient and sample extremes and the count edge cases,
// then randomised carrier tables and i/q transactions under several register
// settings, every output transaction checked against an in-bench predictor
// ----------------------------------------------------------------------------
module iq_upconvert_mixer_core_tb;
    import iqum_pkg::*;

    // pause after the last expected output before touching the registers:
    // a trailing load leaves nothing to wait on
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_WAIT_CYCLES = 20000;
    localparam int TIMEOUT_CYCLES  = 400000;
    localparam int MAX_SHOWN       = 60;

    localparam logic signed [COEF_W-1:0]      COEF_MAX = 16'sh7FFF;
    localparam logic signed [COEF_W-1:0]      COEF_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = 8'sh7F;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = 8'sh80;

    // one input transaction as it crosses mix_in
    typedef struct packed {
        logic                          command;
        logic [ADDR_W-1:0]             phase_index;
        logic signed [COEF_W-1:0]      cos_coef;
        logic signed [COEF_W-1:0]      sin_coef;
        logic signed [SAMPLE_BITS-1:0] i_sample;
        logic signed [SAMPLE_BITS-1:0] q_sample;
    } mix_item_t;

    // one output transaction as it crosses mix_out
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_byte;
        logic                   clipped;
        logic                   last;
        logic [COUNT_W-1:0]     clip_count;
    } mix_result_t;

    // carrier table shadow, register shadow and the queue of predicted bytes
    class upconvert_scoreboard;
        logic signed [COEF_W-1:0] cos_entry [TABLE_DEPTH];
        logic signed [COEF_W-1:0] sin_entry [TABLE_DEPTH];
        logic [COUNT_W-1:0]       run_length;
        logic [SAMPLE_BITS-1:0]   dc_level;
        mix_result_t              expected_samples [$];
        int                       mismatches;

        function new();
            run_length = COUNT_W'(1);
            dc_level   = '0;
            mismatches = 0;
            for (int k = 0; k < TABLE_DEPTH; k++)
            begin
                cos_entry[k] = '0;
                sin_entry[k] = '0;
            end
        endfunction

        task flag_mismatch(string what);
            if (mismatches < MAX_SHOWN)
            begin
                $display("mismatch: %s", what);
            end
            mismatches++;
        endtask

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_UPSAMPLE)
            begin
                run_length = data[COUNT_W-1:0];
            end
            else if (idx == CFG_DC)
            begin
                dc_level = data[SAMPLE_BITS-1:0];
            end
        endfunction

        // sample times q1.15 coefficient, scaled down with truncation toward zero
        function int scaled_term(logic signed [SAMPLE_BITS-1:0] smp,
                                 logic signed [COEF_W-1:0] coef);
            int prod;
            int mag;
            prod = int'(smp) * int'(coef);
            mag  = (prod < 0 ? -prod : prod) >> (COEF_W - 1);
            return (prod < 0) ? -mag : mag;
        endfunction

        function void note_accepted(mix_item_t it);
            int          steps;
            int          total;
            int          clips;
            int          top;
            mix_result_t r;
            if (it.command == CMD_LOAD)
            begin
                cos_entry[it.phase_index] = it.cos_coef;
                sin_entry[it.phase_index] = it.sin_coef;
                return;
            end
            steps = int'(run_length);
            if (steps < 1)
            begin
                steps = 1;
            end
            if (steps > RUN_MAX)
            begin
                steps = RUN_MAX;
            end
            top   = (1 << (SAMPLE_BITS - 1)) - 1;
            clips = 0;
            for (int n = 0; n < steps; n++)
            begin
                total = scaled_term(it.i_sample, cos_entry[n])
                      + scaled_term(it.q_sample, sin_entry[n]);
                r.clipped = 1'b0;
                if (total > top)
                begin
                    total     = top;
                    r.clipped = 1'b1;
                end
                else if (total < -top - 1)
                begin
                    total     = -top - 1;
                    r.clipped = 1'b1;
                end
                if (r.clipped)
                begin
                    clips++;
                end
                r.sample_byte = SAMPLE_BITS'(total) + dc_level;
                r.last        = (n == steps - 1);
                r.clip_count  = r.last ? COUNT_W'(clips) : '0;
                expected_samples.push_back(r);
            end
        endfunction

        task check_output(mix_result_t got);
            mix_result_t want;
            if (expected_samples.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected output byte %02h", got.sample_byte));
                return;
            end
            want = expected_samples.pop_front();
            if (got.sample_byte !== want.sample_byte)
            begin
                flag_mismatch($sformatf("sample_byte %02h, want %02h",
                                        got.sample_byte, want.sample_byte));
            end
            if (got.clipped !== want.clipped)
            begin
                flag_mismatch($sformatf("clipped %b, want %b", got.clipped, want.clipped));
            end
            if (got.last !== want.last)
            begin
                flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
            end
            if (got.clip_count !== want.clip_count)
            begin
                flag_mismatch($sformatf("clip_count %0d, want %0d",
                                        got.clip_count, want.clip_count));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    iqum_in_if  in_ch ();
    iqum_out_if out_ch ();

    upconvert_scoreboard board;

    // chance in a hundred, per cycle, that each side holds back
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    iq_upconvert_mixer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .mix_in    (in_ch),
        .mix_out   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly random coefficients, with the q1.15 extremes and the values
    // zero and minus one turning up often
    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return ($urandom_range(1) != 0) ? -16'sd1 : 16'sd0;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0: return SMP_MAX;
            1: return SMP_MIN;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // a load carries junk in the i/q fields, which the block must ignore
    function automatic mix_item_t make_load(logic [ADDR_W-1:0] idx,
                                            logic signed [COEF_W-1:0] c,
                                            logic signed [COEF_W-1:0] s);
        mix_item_t it;
        it.command     = CMD_LOAD;
        it.phase_index = idx;
        it.cos_coef    = c;
        it.sin_coef    = s;
        it.i_sample    = SAMPLE_BITS'($urandom);
        it.q_sample    = SAMPLE_BITS'($urandom);
        return it;
    endfunction

    // and a mix carries junk in the table fields
    function automatic mix_item_t make_mix(logic signed [SAMPLE_BITS-1:0] i_val,
                                           logic signed [SAMPLE_BITS-1:0] q_val);
        mix_item_t it;
        it.command     = CMD_MIX;
        it.phase_index = ADDR_W'($urandom);
        it.cos_coef    = COEF_W'($urandom);
        it.sin_coef    = COEF_W'($urandom);
        it.i_sample    = i_val;
        it.q_sample    = q_val;
        return it;
    endfunction

    // mode 0: sender idles a little, receiver a lot; mode 1 the reverse;
    // mode 2 nobody idles
    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                src_idle_pct  = 13;
                sink_idle_pct = 66;
            end
            1:
            begin
                src_idle_pct  = 66;
                sink_idle_pct = 13;
            end
            default:
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
        endcase
    endtask

    // present one transaction, with random gaps ahead of it, and hold it
    // until the block takes it; valid stays high into the next call so that
    // back-to-back transactions need no second assignment in a step
    task automatic send_item(input mix_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= it.command;
        in_ch.phase_index <= it.phase_index;
        in_ch.cos_coef    <= it.cos_coef;
        in_ch.sin_coef    <= it.sin_coef;
        in_ch.i_sample    <= it.i_sample;
        in_ch.q_sample    <= it.q_sample;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        board.note_accepted(it);
    endtask

    // wait for the block to go quiet before any register write; callers
    // have already dropped valid
    task automatic settle();
        while (board.expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write enable is left high between back-to-back writes and lowered once
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        board.set_register(idx, data);
    endtask

    task automatic program_registers(input logic [CFG_DATA_W-1:0] count_word,
                                     input logic [CFG_DATA_W-1:0] dc_word);
        settle();
        write_register(CFG_UPSAMPLE, count_word);
        write_register(CFG_DC, dc_word);
        cfg_we <= 1'b0;
    endtask

    // load every carrier entry once, in shuffled order, so that any count
    // setting afterwards reads only written entries
    task automatic fill_table();
        int order [TABLE_DEPTH];
        int j;
        int tmp;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            order[k] = k;
        end
        for (int k = TABLE_DEPTH - 1; k > 0; k--)
        begin
            j        = $urandom_range(k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            send_item(make_load(ADDR_W'(order[k]), pick_coef(), pick_coef()));
        end
        in_ch.valid <= 1'b0;
    endtask

    // one register setting, then a run of mostly mix transactions with the
    // odd reload of a random entry; bit 7 of the count word lies above the
    // register and is set at random
    task automatic run_phase(input int count_val, input logic [CFG_DATA_W-1:0] dc_word,
                             input int n_items);
        logic [CFG_DATA_W-1:0] count_word;
        count_word                 = CFG_DATA_W'(count_val);
        count_word[CFG_DATA_W-1]   = ($urandom_range(1) != 0);
        program_registers(count_word, dc_word);
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_item(make_load(ADDR_W'($urandom), pick_coef(), pick_coef()));
            end
            else
            begin
                send_item(make_mix(pick_sample(), pick_sample()));
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // output side: random back-pressure, every accepted transaction checked
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        mix_result_t got;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.sample_byte = out_ch.sample_byte;
                got.clipped     = out_ch.clipped;
                got.last        = out_ch.last;
                got.clip_count  = out_ch.clip_count;
                board.check_output(got);
            end
            out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int waited;
        board             = new();
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_LOAD;
        in_ch.phase_index = '0;
        in_ch.cos_coef    = '0;
        in_ch.sin_coef    = '0;
        in_ch.i_sample    = '0;
        in_ch.q_sample    = '0;
        set_idling(0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at their reset values: one output per i/q pair, no offset
        // entry 0 holds cos at full positive scale and sin at full negative
        send_item(make_load(ADDR_W'(0), COEF_MAX, COEF_MIN));
        send_item(make_mix(SMP_MAX, SMP_MIN));      // both terms large, clips high
        send_item(make_mix(SMP_MIN, SMP_MAX));      // clips low
        send_item(make_mix(8'sd0, 8'sd0));
        send_item(make_mix(-8'sd1, 8'sd1));         // i product truncates toward zero, q product is exactly minus one
        send_item(make_mix(SMP_MIN, SMP_MIN));      // terms nearly cancel, no clip
        in_ch.valid <= 1'b0;

        // count of zero behaves as one; offset at its top value wraps
        program_registers(CFG_DATA_W'(0), CFG_DATA_W'(255));
        send_item(make_load(ADDR_W'(1), COEF_MIN, 16'sd0));
        send_item(make_load(ADDR_W'(2), 16'sd0, COEF_MAX));
        send_item(make_load(ADDR_W'(3), -16'sd1, 16'sd1));
        send_item(make_mix(SMP_MAX, SMP_MAX));
        send_item(make_mix(SMP_MIN, 8'sd0));
        in_ch.valid <= 1'b0;

        // four phases per pair across entry 0 and the entries just loaded, mid offset
        program_registers(CFG_DATA_W'(4), CFG_DATA_W'(128));
        send_item(make_mix(SMP_MAX, SMP_MIN));
        send_item(make_mix(SMP_MIN, SMP_MAX));
        send_item(make_mix(8'sd5, -8'sd7));
        in_ch.valid <= 1'b0;

        // random part: full table first, then a spread of settings; a count
        // above the table depth clamps to 64, long runs get few transactions
        settle();
        fill_table();
        run_phase(127, '0, 5);
        run_phase(3, CFG_DATA_W'(255), 13);
        set_idling(1);
        run_phase(8, CFG_DATA_W'($urandom), 13);
        run_phase(64, CFG_DATA_W'($urandom), 5);
        set_idling(2);
        run_phase(1, CFG_DATA_W'($urandom), 13);
        run_phase(5, CFG_DATA_W'($urandom), 13);

        // drain, then linger in case anything extra turns up
        waited = 0;
        while (board.expected_samples.size() != 0 && waited < END_WAIT_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (board.expected_samples.size() != 0)
        begin
            board.flag_mismatch($sformatf("%0d expected outputs never arrived",
                                          board.expected_samples.size()));
        end

        if (board.mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin : watchdog
        #(2 * TIMEOUT_CYCLES);
        $display("simulation failed");
        $finish;
    end

endmodule
